### hdl/reu_pkg.sv
// shared types and constants for the risc execute unit
package reu_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned REG_W   = 5;
    localparam int unsigned IMM_W   = 18;
    localparam int unsigned SHAMT_W = 13;
    localparam int unsigned JADDR_W = 28;
    localparam int unsigned OP_W    = 4;
    localparam int unsigned SHIFT_W = 5;

    localparam logic [WORD_W-1:0] PC_HIGH_MASK = 32'hF000_0000;
    localparam logic [WORD_W-1:0] JADDR_MASK   = 32'h0FFF_FFFF;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MULI = 4'd2,
        OP_ADDI = 4'd3,
        OP_BNE  = 4'd4,
        OP_ANDI = 4'd5,
        OP_ORI  = 4'd6,
        OP_J    = 4'd7,
        OP_SLL  = 4'd8,
        OP_SRL  = 4'd9,
        OP_LW   = 4'd10,
        OP_SW   = 4'd11
    } t_opcode;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_LOAD  = 2'd1,
        MEM_STORE = 2'd2
    } t_mem_op;

    typedef struct packed {
        logic [WORD_W-1:0] result_value;
        logic [WORD_W-1:0] mem_address;
        t_mem_op           mem_op;
        logic              writes_register;
        logic [REG_W-1:0]  dest_register;
        logic              branch_taken;
        logic [WORD_W-1:0] next_pc;
        logic              bad_opcode;
    } t_result;

endpackage

### hdl/reu_alu.sv
// combinational decode and alu for one instruction
module reu_alu import reu_pkg::*; (
    input  logic [WORD_W-1:0] i_instruction_word,
    input  logic [WORD_W-1:0] i_operand_a,
    input  logic [WORD_W-1:0] i_operand_b,
    input  logic [WORD_W-1:0] i_operand_c,
    input  logic [WORD_W-1:0] i_pc_plus_one,
    output t_result           o_result
);

    logic [WORD_W-1:0]  imm;
    logic [WORD_W-1:0]  product;
    logic [WORD_W-1:0]  mem_sum;
    logic [SHAMT_W-1:0] shamt;
    logic               shift_big;
    logic [SHIFT_W-1:0] shift_n;

    assign imm       = {{(WORD_W-IMM_W){i_instruction_word[IMM_W-1]}},
                        i_instruction_word[IMM_W-1:0]};
    assign product   = i_operand_b * imm;
    assign mem_sum   = i_operand_b + imm;
    assign shamt     = i_instruction_word[SHAMT_W-1:0];
    assign shift_big = |shamt[SHAMT_W-1:SHIFT_W];
    assign shift_n   = shamt[SHIFT_W-1:0];

    always_comb begin
        o_result                 = '0;
        o_result.mem_op          = MEM_NONE;
        o_result.dest_register   = i_instruction_word[27:23];
        o_result.next_pc         = i_pc_plus_one;
        case (i_instruction_word[WORD_W-1 -: OP_W])
            OP_ADD: begin
                o_result.result_value    = i_operand_b + i_operand_c;
                o_result.writes_register = 1'b1;
            end
            OP_SUB: begin
                o_result.result_value    = i_operand_b - i_operand_c;
                o_result.writes_register = 1'b1;
            end
            OP_MULI: begin
                o_result.result_value    = product;
                o_result.writes_register = 1'b1;
            end
            OP_ADDI: begin
                o_result.result_value    = mem_sum;
                o_result.writes_register = 1'b1;
            end
            OP_BNE: begin
                if (i_operand_a != i_operand_b) begin
                    o_result.branch_taken = 1'b1;
                    o_result.next_pc      = i_pc_plus_one + imm;
                end
            end
            OP_ANDI: begin
                o_result.result_value    = i_operand_b & imm;
                o_result.writes_register = 1'b1;
            end
            OP_ORI: begin
                o_result.result_value    = i_operand_b | imm;
                o_result.writes_register = 1'b1;
            end
            OP_J: begin
                o_result.branch_taken = 1'b1;
                o_result.next_pc      = (i_pc_plus_one & PC_HIGH_MASK)
                                      | (i_instruction_word & JADDR_MASK);
            end
            OP_SLL: begin
                o_result.result_value    = shift_big ? '0 : (i_operand_b << shift_n);
                o_result.writes_register = 1'b1;
            end
            OP_SRL: begin
                o_result.result_value    = shift_big ? '0 : (i_operand_b >> shift_n);
                o_result.writes_register = 1'b1;
            end
            OP_LW: begin
                o_result.mem_address = mem_sum;
                o_result.mem_op      = MEM_LOAD;
            end
            OP_SW: begin
                o_result.mem_address = mem_sum;
                o_result.mem_op      = MEM_STORE;
            end
            default: begin
                o_result.bad_opcode = 1'b1;
            end
        endcase
    end

endmodule

### hdl/risc_execute_unit.sv
// top level of the risc execute unit: input register, alu, result register
//
//  channel  direction  handshake                 payload
//  in       sink       i_in_valid / o_in_ready   instruction word, operands a b c, pc+1
//  out      source     o_out_valid / i_out_ready result, mem address/op, dest, branch, flags
//
// a result is registered in the input register and then in the result register before
// it shows on the outputs, so its output transaction comes after both registers
// one transaction per cycle is sustained while the output takes every result; the alu
// (one 32x32 multiply) sits between the input register and the result register
// synchronous active-low reset clears both valid flags; payload is not reset
// a stall on the output holds the result register, and the input register
// still takes a new transaction while it is empty
module risc_execute_unit import reu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic        [WORD_W-1:0] i_instruction_word,
    input  logic signed [WORD_W-1:0] i_operand_a,
    input  logic signed [WORD_W-1:0] i_operand_b,
    input  logic signed [WORD_W-1:0] i_operand_c,
    input  logic        [WORD_W-1:0] i_pc_plus_one,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [WORD_W-1:0] o_result_value,
    output logic signed [WORD_W-1:0] o_mem_address,
    output logic        [1:0]        o_mem_op,
    output logic                     o_writes_register,
    output logic        [REG_W-1:0]  o_dest_register,
    output logic                     o_branch_taken,
    output logic        [WORD_W-1:0] o_next_pc,
    output logic                     o_bad_opcode
);

    // input stage
    logic              r_s1_valid, n_s1_valid;
    logic [WORD_W-1:0] r_word, r_a, r_b, r_c, r_pc1;

    // result stage
    logic              r_s2_valid, n_s2_valid;
    t_result           r_res;
    t_result           alu_res;

    logic              s2_load;

    // result stage takes a new transaction when empty or being drained
    assign s2_load    = r_s1_valid && (!r_s2_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s2_load;

    always_comb begin
        n_s1_valid = o_in_ready ? i_in_valid : r_s1_valid;
        if (s2_load) begin
            n_s2_valid = 1'b1;
        end else if (i_out_ready) begin
            n_s2_valid = 1'b0;
        end else begin
            n_s2_valid = r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_word <= i_instruction_word;
            r_a    <= i_operand_a;
            r_b    <= i_operand_b;
            r_c    <= i_operand_c;
            r_pc1  <= i_pc_plus_one;
        end
        if (s2_load) begin
            r_res <= alu_res;
        end
    end

    reu_alu u_alu (
        .i_instruction_word (r_word),
        .i_operand_a        (r_a),
        .i_operand_b        (r_b),
        .i_operand_c        (r_c),
        .i_pc_plus_one      (r_pc1),
        .o_result           (alu_res)
    );

    assign o_out_valid       = r_s2_valid;
    assign o_result_value    = r_res.result_value;
    assign o_mem_address     = r_res.mem_address;
    assign o_mem_op          = r_res.mem_op;
    assign o_writes_register = r_res.writes_register;
    assign o_dest_register   = r_res.dest_register;
    assign o_branch_taken    = r_res.branch_taken;
    assign o_next_pc         = r_res.next_pc;
    assign o_bad_opcode      = r_res.bad_opcode;

endmodule

### hdl/reu_checker.sv
// port-level assertions for the risc execute unit and their bind
module reu_checker import reu_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [WORD_W-1:0] o_result_value,
    input logic        [1:0]        o_mem_op,
    input logic                     o_writes_register,
    input logic                     o_branch_taken,
    input logic                     o_bad_opcode
);

    // nothing shows on the output right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_value))
        else $error("stalled result changed");

    // an unused opcode causes no side effect
    a_bad_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_opcode |->
            !o_writes_register && !o_branch_taken && o_mem_op == MEM_NONE
            && o_result_value == '0)
        else $error("bad opcode with side effect");

    // memory transactions never write a register or branch
    a_mem_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mem_op != MEM_NONE |-> !o_writes_register && !o_branch_taken)
        else $error("memory op mixed with write or branch");

    // result value is zero whenever no register is written
    a_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_writes_register |-> o_result_value == '0)
        else $error("nonzero result without register write");

endmodule

bind risc_execute_unit reu_checker u_reu_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_result_value    (o_result_value),
    .o_mem_op          (o_mem_op),
    .o_writes_register (o_writes_register),
    .o_branch_taken    (o_branch_taken),
    .o_bad_opcode      (o_bad_opcode)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the risc execute unit with handshake idling and stalls
module tb_top import reu_pkg::*; ();

    // opcodes 12 to 15 carry no operation
    localparam logic [OP_W-1:0] FIRST_UNUSED_OP = 4'd12;
    localparam int              LONG_HOLD       = 300;
    localparam int              DRAIN_CYCLES    = 8;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [WORD_W-1:0] i_instruction_word = '0;
    logic [WORD_W-1:0] i_operand_a = '0;
    logic [WORD_W-1:0] i_operand_b = '0;
    logic [WORD_W-1:0] i_operand_c = '0;
    logic [WORD_W-1:0] i_pc_plus_one = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [WORD_W-1:0] o_result_value;
    logic [WORD_W-1:0] o_mem_address;
    logic [1:0]        o_mem_op;
    logic              o_writes_register;
    logic [REG_W-1:0]  o_dest_register;
    logic              o_branch_taken;
    logic [WORD_W-1:0] o_next_pc;
    logic              o_bad_opcode;

    t_result pending_results[$];
    int      error_count = 0;
    int      instr_count = 0;
    int      results_checked = 0;
    int      taken_count = 0;
    int      bad_op_count = 0;
    int      burst_left = 0;
    bit      tx_steady = 1'b0;
    bit      rx_free = 1'b0;
    bit      hold_request = 1'b0;

    risc_execute_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_instruction_word (i_instruction_word),
        .i_operand_a        (i_operand_a),
        .i_operand_b        (i_operand_b),
        .i_operand_c        (i_operand_c),
        .i_pc_plus_one      (i_pc_plus_one),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_result_value     (o_result_value),
        .o_mem_address      (o_mem_address),
        .o_mem_op           (o_mem_op),
        .o_writes_register  (o_writes_register),
        .o_dest_register    (o_dest_register),
        .o_branch_taken     (o_branch_taken),
        .o_next_pc          (o_next_pc),
        .o_bad_opcode       (o_bad_opcode)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // expected outcome of one instruction in the execute stage
    function automatic t_result execute_instr(logic [WORD_W-1:0] word, logic [WORD_W-1:0] a,
                                              logic [WORD_W-1:0] b, logic [WORD_W-1:0] c,
                                              logic [WORD_W-1:0] pc1);
        t_result             r;
        logic [WORD_W-1:0]   imm;
        logic [SHAMT_W-1:0]  shamt;
        r               = '0;
        r.mem_op        = MEM_NONE;
        r.next_pc       = pc1;
        r.dest_register = word[27:23];
        imm             = {{(WORD_W-IMM_W){word[IMM_W-1]}}, word[IMM_W-1:0]};
        shamt           = word[SHAMT_W-1:0];
        case (word[31:28])
            OP_ADD: begin
                r.result_value = b + c;
                r.writes_register = 1'b1;
            end
            OP_SUB: begin
                r.result_value = b - c;
                r.writes_register = 1'b1;
            end
            OP_MULI: begin
                r.result_value = b * imm;
                r.writes_register = 1'b1;
            end
            OP_ADDI: begin
                r.result_value = b + imm;
                r.writes_register = 1'b1;
            end
            OP_BNE: begin
                if (a != b) begin
                    r.branch_taken = 1'b1;
                    r.next_pc = pc1 + imm;
                end
            end
            OP_ANDI: begin
                r.result_value = b & imm;
                r.writes_register = 1'b1;
            end
            OP_ORI: begin
                r.result_value = b | imm;
                r.writes_register = 1'b1;
            end
            OP_J: begin
                r.branch_taken = 1'b1;
                r.next_pc = (pc1 & PC_HIGH_MASK) | (word & JADDR_MASK);
            end
            OP_SLL: begin
                r.result_value = (shamt >= WORD_W) ? '0 : b << shamt[SHIFT_W-1:0];
                r.writes_register = 1'b1;
            end
            OP_SRL: begin
                r.result_value = (shamt >= WORD_W) ? '0 : b >> shamt[SHIFT_W-1:0];
                r.writes_register = 1'b1;
            end
            OP_LW: begin
                r.mem_address = b + imm;
                r.mem_op = MEM_LOAD;
            end
            OP_SW: begin
                r.mem_address = b + imm;
                r.mem_op = MEM_STORE;
            end
            default: r.bad_opcode = 1'b1;
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [WORD_W-1:0] exp_val,
                                        logic [WORD_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %h, got %h", name, exp_val, act_val);
            error_count++;
        end
    endfunction

    function automatic logic [WORD_W-1:0] enc(logic [OP_W-1:0] op, logic [REG_W-1:0] rd,
                                              logic [22:0] low);
        return {op, rd, low};
    endfunction

    function automatic logic [WORD_W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    // result side is checked first, then the accepted instruction is queued
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with no instruction outstanding");
                    error_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    check_field("result_value", exp_res.result_value, o_result_value);
                    check_field("mem_address", exp_res.mem_address, o_mem_address);
                    check_field("mem_op", WORD_W'(exp_res.mem_op), WORD_W'(o_mem_op));
                    check_field("writes_register", WORD_W'(exp_res.writes_register),
                                WORD_W'(o_writes_register));
                    check_field("dest_register", WORD_W'(exp_res.dest_register),
                                WORD_W'(o_dest_register));
                    check_field("branch_taken", WORD_W'(exp_res.branch_taken),
                                WORD_W'(o_branch_taken));
                    check_field("next_pc", exp_res.next_pc, o_next_pc);
                    check_field("bad_opcode", WORD_W'(exp_res.bad_opcode),
                                WORD_W'(o_bad_opcode));
                    results_checked++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                exp_res = execute_instr(i_instruction_word, i_operand_a, i_operand_b,
                                        i_operand_c, i_pc_plus_one);
                pending_results.push_back(exp_res);
                instr_count++;
                if (exp_res.branch_taken) taken_count++;
                if (exp_res.bad_opcode) bad_op_count++;
            end
        end
    end

    // receiver: phases of free flow, random, sparse and alternating ready, plus a long hold on request
    always @(posedge i_clk) begin
        int hold_left;
        int phase_left;
        int phase_kind;
        if (hold_request && hold_left == 0) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (rx_free) begin
            i_out_ready <= 1'b1;
        end else begin
            if (phase_left <= 0) begin
                phase_left = $urandom_range(4, 40);
                phase_kind = $urandom_range(0, 3);
            end
            phase_left--;
            case (phase_kind)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= ~i_out_ready;
            endcase
        end
    end

    // sender: bursts of random length with random gaps, valid held until accepted
    task automatic send_instr(input logic [WORD_W-1:0] word, input logic [WORD_W-1:0] a,
                              input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] c,
                              input logic [WORD_W-1:0] pc1);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = tx_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid         <= 1'b1;
        i_instruction_word <= word;
        i_operand_a        <= a;
        i_operand_b        <= b;
        i_operand_c        <= c;
        i_pc_plus_one      <= pc1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic send_random_instr();
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        word = $urandom;
        a    = pick_operand();
        b    = pick_operand();
        // mostly defined opcodes, the unused ones now and then
        if ($urandom_range(0, 7) != 0) word[31:28] = OP_W'($urandom_range(0, 11));
        case (word[31:28])
            OP_BNE: begin
                if ($urandom_range(0, 1) == 0) b = a;
            end
            OP_SLL, OP_SRL: begin
                if ($urandom_range(0, 3) != 0) begin
                    word[SHAMT_W-1:0] = SHAMT_W'($urandom_range(0, 31));
                end else if ($urandom_range(0, 1) == 0) begin
                    word[SHAMT_W-1:0] = SHAMT_W'($urandom_range(32, 40));
                end
            end
            default: ;
        endcase
        send_instr(word, a, b, pick_operand(), pick_operand());
    endtask

    // extremes of every opcode, wrapping, large and logical shifts, unused opcodes
    task automatic test_directed();
        send_instr(enc(OP_ADD, 5'd31, 23'h0), 0, 32'h7FFF_FFFF, 32'h1, 32'h10);
        send_instr(enc(OP_SUB, 5'd0, 23'h0), 0, 32'h8000_0000, 32'h1, 32'h10);
        send_instr(enc(OP_MULI, 5'd1, 23'h3FFFF), 0, 32'hFFFF_FFFD, 0, 32'h10);
        send_instr(enc(OP_MULI, 5'd2, 23'h1FFFF), 0, 32'h1234_5678, 0, 32'h10);
        send_instr(enc(OP_ADDI, 5'd3, 23'h20000), 0, 32'h7FFF_FFFF, 0, 32'h10);
        send_instr(enc(OP_ADDI, 5'd4, 23'h1FFFF), 0, 32'hFFFF_FFFF, 0, 32'h10);
        send_instr(enc(OP_BNE, 5'd5, 23'h00123), 32'h55, 32'h55, 0, 32'h100);
        send_instr(enc(OP_BNE, 5'd6, 23'h20000), 32'h1, 32'h2, 0, 32'h0);
        send_instr(enc(OP_BNE, 5'd7, 23'h00001), 32'h8000_0000, 32'h7FFF_FFFF, 0,
                   32'hFFFF_FFFF);
        send_instr(enc(OP_ANDI, 5'd8, 23'h20000), 0, 32'hFFFF_FFFF, 0, 32'h10);
        send_instr(enc(OP_ORI, 5'd9, 23'h3FFFF), 0, 32'h0, 0, 32'h10);
        send_instr(enc(OP_J, 5'h1F, 23'h7FFFFF), 0, 0, 0, 32'hF000_0001);
        send_instr(enc(OP_J, 5'd0, 23'h0), 0, 0, 0, 32'h7FFF_FFFF);
        send_instr(enc(OP_SLL, 5'd10, 23'h0), 0, 32'hDEAD_BEEF, 0, 32'h10);
        send_instr(enc(OP_SLL, 5'd11, 23'd31), 0, 32'hFFFF_FFFF, 0, 32'h10);
        send_instr(enc(OP_SLL, 5'd12, 23'd32), 0, 32'hFFFF_FFFF, 0, 32'h10);
        send_instr(enc(OP_SLL, 5'd13, 23'h1FFF), 0, 32'hFFFF_FFFF, 0, 32'h10);
        send_instr(enc(OP_SRL, 5'd14, 23'd1), 0, 32'h8000_0000, 0, 32'h10);
        send_instr(enc(OP_SRL, 5'd15, 23'd31), 0, 32'hFFFF_FFFF, 0, 32'h10);
        send_instr(enc(OP_SRL, 5'd16, 23'd33), 0, 32'hFFFF_FFFF, 0, 32'h10);
        send_instr(enc(OP_LW, 5'd17, 23'h00001), 0, 32'h7FFF_FFFF, 0, 32'h10);
        send_instr(enc(OP_SW, 5'd18, 23'h20000), 32'hCAFE_F00D, 32'h0, 0, 32'h10);
        for (int k = 0; k < 4; k++) begin
            send_instr(enc(OP_W'(FIRST_UNUSED_OP + k), 5'(k), 23'h7FFFFF), 32'hFFFF_FFFF,
                       32'h1, 32'h2, 32'h1234_5678);
        end
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_random_instr();
    endtask

    // receiver holds off while the sender keeps offering, so the input side backs up
    task automatic test_output_backpressure(input int count);
        tx_steady = 1'b1;
        hold_request = 1'b1;
        repeat (count) send_random_instr();
        tx_steady = 1'b0;
    endtask

    // no idling on either side: one transaction every cycle
    task automatic test_full_rate(input int count);
        tx_steady = 1'b1;
        rx_free = 1'b1;
        repeat (count) send_random_instr();
        tx_steady = 1'b0;
        rx_free = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_mix(800);
        test_output_backpressure(80);
        test_full_rate(150);
        test_random_mix(800);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d instructions, %0d results checked field by field",
                 instr_count, results_checked);
        $display("branches taken %0d, unused opcodes %0d, long output hold and full rate run",
                 taken_count, bad_op_count);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### files.f
hdl/reu_pkg.sv
hdl/reu_alu.sv
hdl/risc_execute_unit.sv
hdl/reu_checker.sv
tb/tb_top.sv
